>>> rtl/foc_pkg.sv
// Package for the 3x3 corner detector: sizes, register indexes and shared types.
// Depends on nothing; every other file of the block imports it.
package foc_pkg;

    localparam int GRAD_BITS = 12;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int THR_W     = 12;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int RESP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int PAIR_W = 2 * GRAD_BITS;
    localparam int S_W    = 2 * GRAD_BITS + 3;
    localparam int T_W    = S_W + 1;
    localparam int N_W    = 2 * S_W;
    localparam int T2_W   = 2 * T_W;
    localparam int RHS_W  = T2_W + THR_W;
    localparam int NUM_W  = N_W + 10;
    localparam int DEN_W  = T_W + 5;
    localparam int CMP_W  = (RHS_W > NUM_W) ? RHS_W : NUM_W;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    typedef logic signed [GRAD_BITS-1:0] grad_t;

    typedef struct packed {
        grad_t gy;
        grad_t gx;
    } pair_t;

    typedef struct packed {
        logic start;
        logic ack;
    } resp_req_t;

    typedef struct packed {
        logic                done;
        logic [RESP_W-1:0]   value;
    } resp_stat_t;

endpackage

>>> rtl/foc_linebuf.sv
// Line store: one synchronous memory holding the two rows above, one word per column.
// Registered read, one write port. Uses foc_pkg.
module foc_linebuf (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [foc_pkg::COL_W-1:0]      rd_addr,
    output logic [2*foc_pkg::PAIR_W-1:0]   rd_data,
    input  logic                           wr_en,
    input  logic [foc_pkg::COL_W-1:0]      wr_addr,
    input  logic [2*foc_pkg::PAIR_W-1:0]   wr_data
);
    import foc_pkg::*;

    logic [2*PAIR_W-1:0] mem [0:MAX_WIDTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/foc_resp.sv
// Response unit: accumulates the window sums, forms N and T, tests the threshold
// and divides bit by bit for the rounded, saturated response. Uses foc_pkg.
module foc_resp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  foc_pkg::resp_req_t          req,
    input  foc_pkg::pair_t              win [0:8],
    input  logic [foc_pkg::THR_W-1:0]   threshold,
    output foc_pkg::resp_stat_t         stat
);
    import foc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_MUL3 = 4'd4;
    localparam logic [3:0] ST_MUL4 = 4'd5;
    localparam logic [3:0] ST_CMP  = 4'd6;
    localparam logic [3:0] ST_SAT  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]              state_reg;
    logic [3:0]              idx_reg;
    logic [3:0]              step_reg;
    logic [S_W-1:0]          sxx_reg, syy_reg, axy_reg;
    logic signed [S_W:0]     sxy_reg;
    logic [T_W-1:0]          t_reg;
    logic [N_W-1:0]          p_reg, q_reg, n_reg;
    logic [T2_W-1:0]         t2_reg;
    logic [RHS_W-1:0]        rhs_reg;
    logic [NUM_W-1:0]        rem_reg, dsh_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [RESP_W-1:0]       quo_reg;

    pair_t                   cur;
    logic signed [2*GRAD_BITS-1:0] pxx, pyy, pxy;
    logic [CMP_W-1:0]        lhs_ext, rhs_ext;
    logic [NUM_W-1:0]        num, den_top;

    always_comb begin
        cur     = win[idx_reg];
        pxx     = cur.gx * cur.gx;
        pyy     = cur.gy * cur.gy;
        pxy     = cur.gx * cur.gy;
        lhs_ext = CMP_W'({n_reg, 10'd0});
        rhs_ext = CMP_W'(rhs_reg);
        num     = NUM_W'({n_reg, 10'd0}) - NUM_W'({n_reg, 2'd0})
                  + NUM_W'(t_reg) * NUM_W'(9);
        den_top = NUM_W'(den_reg) << RESP_W;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        state_reg <= ST_SUM;
                        idx_reg   <= '0;
                        sxx_reg   <= '0;
                        syy_reg   <= '0;
                        sxy_reg   <= '0;
                    end
                end
                ST_SUM: begin
                    sxx_reg <= sxx_reg + S_W'(unsigned'(pxx));
                    syy_reg <= syy_reg + S_W'(unsigned'(pyy));
                    sxy_reg <= sxy_reg + (S_W+1)'(pxy);
                    if (idx_reg == 4'd8) begin
                        state_reg <= ST_MUL1;
                    end else begin
                        idx_reg <= idx_reg + 4'd1;
                    end
                end
                ST_MUL1: begin
                    p_reg     <= N_W'(sxx_reg) * N_W'(syy_reg);
                    t_reg     <= T_W'(sxx_reg) + T_W'(syy_reg);
                    axy_reg   <= sxy_reg[S_W] ? S_W'(-sxy_reg) : S_W'(sxy_reg);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    q_reg     <= N_W'(axy_reg) * N_W'(axy_reg);
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    n_reg     <= p_reg - q_reg;
                    t2_reg    <= T2_W'(t_reg) * T2_W'(t_reg);
                    state_reg <= ST_MUL4;
                end
                ST_MUL4: begin
                    rhs_reg   <= RHS_W'(t2_reg) * RHS_W'(threshold);
                    den_reg   <= DEN_W'(t_reg) * DEN_W'(18);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if ((t_reg == '0) || (lhs_ext < rhs_ext)) begin
                        quo_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        rem_reg   <= num;
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    if (rem_reg >= den_top) begin
                        quo_reg   <= '1;
                        state_reg <= ST_DONE;
                    end else begin
                        quo_reg   <= '0;
                        dsh_reg   <= den_top >> 1;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        quo_reg <= {quo_reg[RESP_W-2:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[RESP_W-2:0], 1'b0};
                    end
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(RESP_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (req.ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.done  = (state_reg == ST_DONE);
    assign stat.value = quo_reg;

endmodule

>>> rtl/foerstner_corner_2d_core.sv
// 3x3 corner detector on a raster stream of gradient pairs; top level.
// An edge pixel passes only through the idle and read states. An interior pixel whose
// response is divided out goes through 9 accumulation steps, 4 multiply steps, compare,
// saturation check, 16 divide steps and hand-off; a rejected one skips the saturation check
// and division, a saturated one the division. No new pixel is taken until the last result is
// loaded, which waits for m_tready. aresetn is synchronous: counters, window, maximum and
// configuration registers return to reset values. Uses foc_pkg, foc_linebuf and foc_resp.
module foerstner_corner_2d_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // grad_x, grad_y
    input  logic [0:0]                       s_tuser,   // start_of_frame
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // response, center_col, center_row, frame_max
    output logic                             m_tlast,   // end_of_frame
    input  logic                             cfg_we,
    input  logic [foc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [foc_pkg::CFG_W-1:0]        cfg_wdata
);
    import foc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]          state_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [WID_W-1:0]    wid_reg;
    logic [HGT_W-1:0]    hgt_reg;
    logic [COL_W-1:0]    col_reg, cur_c_reg;
    logic [ROW_W-1:0]    row_reg, cur_r_reg;
    logic [RESP_W-1:0]   max_reg;
    logic                last_reg, interior_reg;
    pair_t               pix_reg;
    pair_t               win_reg [0:8];
    logic                out_valid_reg;
    logic [63:0]         out_data_reg;
    logic                out_last_reg;

    logic                        accept, load_out, out_free;
    logic [COL_W-1:0]            c_use;
    logic [ROW_W-1:0]            r_use;
    logic [WID_W-1:0]            w_eff;
    logic [HGT_W-1:0]            h_eff;
    logic                        col_end, row_end;
    logic [2*PAIR_W-1:0]         rd_data;
    pair_t                       up2, up1;
    resp_req_t                   req;
    resp_stat_t                  stat;
    logic [RESP_W-1:0]           max_new;

    foc_linebuf u_linebuf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (c_use),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_RD),
        .wr_addr (cur_c_reg),
        .wr_data ({pix_reg, up1})
    );

    foc_resp u_resp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .win       (win_reg),
        .threshold (thr_reg),
        .stat      (stat)
    );

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && s_tready;
        c_use    = s_tuser[0] ? '0 : col_reg;
        r_use    = s_tuser[0] ? '0 : row_reg;
        w_eff    = wid_reg;
        if (wid_reg < WID_W'(3)) begin
            w_eff = WID_W'(3);
        end else if (wid_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        h_eff    = (hgt_reg < HGT_W'(3)) ? HGT_W'(3) : hgt_reg;
        col_end  = (WID_W'(c_use) + WID_W'(1)) >= w_eff;
        row_end  = ({1'b0, r_use} + 17'd1) >= {1'b0, h_eff};
        up2      = rd_data[PAIR_W-1:0];
        up1      = rd_data[2*PAIR_W-1:PAIR_W];
        out_free = !out_valid_reg || m_tready;
        load_out = (state_reg == ST_WAIT) && stat.done && out_free;
        req.start = (state_reg == ST_RD) && interior_reg;
        req.ack   = load_out;
        max_new   = (stat.value > max_reg) ? stat.value : max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(128);
            wid_reg <= WID_W'(1024);
            hgt_reg <= HGT_W'(1024);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                REG_WIDTH:     wid_reg <= cfg_wdata[WID_W-1:0];
                REG_HEIGHT:    hgt_reg <= cfg_wdata[HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        pix_reg      <= s_tdata;
                        cur_c_reg    <= c_use;
                        cur_r_reg    <= r_use;
                        last_reg     <= col_end && row_end;
                        interior_reg <= (c_use >= COL_W'(2)) && (r_use >= ROW_W'(2));
                        if (c_use == '0 && r_use == '0) begin
                            max_reg <= '0;
                        end
                        if (col_end) begin
                            col_reg <= '0;
                            row_reg <= row_end ? '0 : r_use + ROW_W'(1);
                        end else begin
                            col_reg <= c_use + COL_W'(1);
                            row_reg <= r_use;
                        end
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    for (int i = 0; i < 3; i++) begin
                        win_reg[3*i]   <= win_reg[3*i+1];
                        win_reg[3*i+1] <= win_reg[3*i+2];
                    end
                    win_reg[2] <= up2;
                    win_reg[5] <= up1;
                    win_reg[8] <= pix_reg;
                    state_reg  <= interior_reg ? ST_WAIT : ST_IDLE;
                end
                ST_WAIT: begin
                    if (load_out) begin
                        max_reg   <= max_new;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {6'd0, max_new, ROW_W'(cur_r_reg - ROW_W'(1)),
                             COL_W'(cur_c_reg - COL_W'(1)), stat.value};
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
